// ===== rtl/core/bonded_key_table_defines.svh =====
// ----------------------------------------------------------------------------
// bonded_key_table_defines.svh
// Assertion macros used by the bonded key table RTL.
// ----------------------------------------------------------------------------
`ifndef BONDED_KEY_TABLE_DEFINES_SVH
`define BONDED_KEY_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BKT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("bonded key table: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error("bonded key table: assertion failed");

`endif

// ===== rtl/core/bkt_pkg.sv =====
// ----------------------------------------------------------------------------
// bkt_pkg
// Types and constants of the bonded key table.
// ----------------------------------------------------------------------------
`default_nettype none

package bkt_pkg;

  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned IDX_W       = 3;   // slot field width
  localparam int unsigned CNT_W       = 4;   // entry count field width
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned KEY_W       = 64;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_STORE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_KEY
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/bonded_key_table.sv =====
// ----------------------------------------------------------------------------
// bonded_key_table
// Associative table of bonded peers: lookup and store of link keys by address.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per transfer: func_i selects a
//   lookup or a store, peer_address_i is the search key, and the two key
//   words are used by a store only. The output channel returns exactly one
//   result per request, in request order: status, slot, key words (lookup
//   hit only) and the entry count after the operation.
//   Scan: the address memory has a single read port, so the scan visits
//   one filled entry per cycle and stops at a hit. The result register is
//   loaded when the scan ends; a lookup hit first reads the key memory in
//   the key state. The block takes one request at a time, so a new request
//   is taken only after the previous result has been loaded.
//   Reset clears the entry count and all control state; the memories are not
//   cleared, since only filled entries are ever read.
//   When the receiver stalls, the result waits in the output register and the
//   next request is still taken; its scan runs, but its result and any table
//   write wait until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bonded_key_table
  import bkt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              func_i,
  input  wire logic [ADDR_W-1:0] peer_address_i,
  input  wire logic [KEY_W-1:0]  key_upper_in_i,
  input  wire logic [KEY_W-1:0]  key_lower_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic [IDX_W-1:0]       slot_o,
  output logic [KEY_W-1:0]       key_upper_out_o,
  output logic [KEY_W-1:0]       key_lower_out_o,
  output logic [CNT_W-1:0]       entry_count_o
);

`include "bonded_key_table_defines.svh"

  // Request registers, captured at the input transfer.
  func_e             func_q;
  logic [ADDR_W-1:0] addr_q;
  logic [KEY_W-1:0]  kup_q;
  logic [KEY_W-1:0]  klo_q;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  // The read index runs up to the count itself, so it has the count's width.
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;

  // Memories: address per entry, and both key words side by side.
  logic [ADDR_W-1:0]  addr_mem [TABLE_DEPTH];
  logic [2*KEY_W-1:0] key_mem  [TABLE_DEPTH];
  logic [ADDR_W-1:0]  addr_rdata_q;
  logic [2*KEY_W-1:0] key_rdata_q;
  logic               addr_re, addr_we, key_re, key_we;
  logic [IDX_W-1:0]   wr_idx;

  // Result register.
  logic             out_valid_q;
  status_e          status_q;
  logic [IDX_W-1:0] slot_q;
  logic [KEY_W-1:0] oup_q, olo_q;

  logic             load_res;
  status_e          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [KEY_W-1:0] res_kup, res_klo;

  logic hit, scan_end, out_free, table_full;

  // A compare is pending when the previous cycle issued a read; the read data
  // holds while no new read is issued, so a stalled decision stays valid.
  assign hit        = cmp_vld_q && (addr_rdata_q == addr_q);
  assign scan_end   = (rd_idx_q >= count_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (count_q >= CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (in_valid_i && in_ready_o) begin
      func_q <= func_e'(func_i);
      addr_q <= peer_address_i;
      kup_q  <= key_upper_in_i;
      klo_q  <= key_lower_in_i;
    end
  end

  // Sequencer: scan the filled entries, then read a key, write back or report the result.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    addr_re    = 1'b0;
    addr_we    = 1'b0;
    key_re     = 1'b0;
    key_we     = 1'b0;
    wr_idx     = cmp_idx_q;
    in_ready_o = 1'b0;
    load_res   = 1'b0;
    res_status = STATUS_OK;
    res_slot   = '0;
    res_kup    = '0;
    res_klo    = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d   = ST_SCAN;
          rd_idx_d  = '0;
          cmp_vld_d = 1'b0;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          if (func_q == FUNC_LOOKUP) begin
            key_re  = 1'b1;
            state_d = ST_KEY;
          end else if (out_free) begin
            // Store to a known peer: overwrite its key in place.
            key_we    = 1'b1;
            wr_idx    = cmp_idx_q;
            load_res  = 1'b1;
            res_slot  = cmp_idx_q;
            cmp_vld_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end else if (!scan_end) begin
          addr_re   = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end else if (out_free) begin
          load_res  = 1'b1;
          cmp_vld_d = 1'b0;
          state_d   = ST_IDLE;
          if (func_q == FUNC_LOOKUP) begin
            res_status = STATUS_NOT_FOUND;
          end else if (table_full) begin
            res_status = STATUS_FULL;
          end else begin
            // Append the new peer at the first free slot.
            addr_we  = 1'b1;
            key_we   = 1'b1;
            wr_idx   = count_q[IDX_W-1:0];
            res_slot = count_q[IDX_W-1:0];
            count_d  = count_q + CNT_W'(1);
          end
        end
      end

      ST_KEY: begin
        if (out_free) begin
          load_res  = 1'b1;
          res_slot  = cmp_idx_q;
          res_kup   = key_rdata_q[2*KEY_W-1:KEY_W];
          res_klo   = key_rdata_q[KEY_W-1:0];
          cmp_vld_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reads and writes never target the same cycle of one request, and a new
  // request starts reading only after the previous write-back, so no
  // forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[wr_idx] <= addr_q;
    end
    if (addr_re) begin
      addr_rdata_q <= addr_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= {kup_q, klo_q};
    end
    if (key_re) begin
      key_rdata_q <= key_mem[cmp_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      oup_q    <= res_kup;
      olo_q    <= res_klo;
    end
  end

  // The count changes only when a result is loaded, so it stays matched to
  // the result that waits in the output register.
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign key_upper_out_o = oup_q;
  assign key_lower_out_o = olo_q;
  assign entry_count_o   = count_q;

  `BKT_ASSERT_IMPLIES(a_count_max, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
  `BKT_ASSERT_IMPLIES(a_count_step, count_q != $past(count_q),
                      count_q == $past(count_q) + CNT_W'(1))
  `BKT_ASSERT_IMPLIES(a_cmp_range, cmp_vld_q, {1'b0, cmp_idx_q} < count_q)
  `BKT_ASSERT_IMPLIES(a_full_count, out_valid_q && status_q == STATUS_FULL,
                      count_q == CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire
